/* src/matrix_vector_multiply_assert.svh */
// Assertion macros shared by the matrix-vector multiply checker.
// Each macro expands to one labeled concurrent assertion on i_clk.
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MVM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled.
`define MVM_ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* src/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// Types, widths and sizing constants of the matrix-vector multiply block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

    // Vector store depth (number of columns the store can hold).
    localparam int MAX_COLS = 1024;
    localparam int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Field widths.
    localparam int COL_W  = 10;
    localparam int VAL_W  = 16;
    localparam int ROW_W  = 16;
    localparam int CCNT_W = 11;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = 48;
    localparam int CFG_W  = 16;

    // Largest column count in use: bounded by the store and the column field.
    localparam int COL_LIMIT = (MAX_COLS < (1 << COL_W)) ? MAX_COLS : (1 << COL_W);
    localparam logic [CCNT_W-1:0] COL_LIMIT_C = CCNT_W'(COL_LIMIT);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Result buffer at the back end.
    localparam int OUT_DEPTH = 4;
    localparam int O_PTR_W   = $clog2(OUT_DEPTH);
    localparam int O_CNT_W   = $clog2(OUT_DEPTH + 1);

    // Item commands.
    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_MATRIX = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_COL_COUNT = 1'b0,
        CFG_ROW_COUNT = 1'b1
    } t_cfg_index;

    // Classified request handed from front to back.
    typedef struct packed {
        t_cmd                    cmd;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
        logic                    last_col;
        logic                    in_range;
    } t_item;

    // Multiply stage contents.
    typedef struct packed {
        t_cmd                     cmd;
        logic                     last_col;
        logic signed [PROD_W-1:0] prod;
    } t_stage2;

    // Finished row.
    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last_row;
    } t_result;

endpackage

`default_nettype wire

/* src/mvm_front.sv */
// ----------------------------------------------------------------------------
// mvm_front
// Accepts input requests, marks the row-closing column and the columns that
// fall inside the vector store, and hands them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [mvm_pkg::CCNT_W-1:0]    i_col_count,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [0:0]                    i_command,
    input  wire logic [mvm_pkg::COL_W-1:0]     i_column,
    input  wire logic signed [mvm_pkg::VAL_W-1:0] i_value,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output mvm_pkg::t_item                     o_q_item
);

    logic                          r_valid;
    logic                          n_valid;
    mvm_pkg::t_item                r_item;
    logic                          accept;
    logic [mvm_pkg::CCNT_W-1:0]    cols_in_use;
    logic [mvm_pkg::CCNT_W-1:0]    last_col_idx;
    mvm_pkg::t_item                cls_item;

    // Clamp the column count to the range the store supports.
    always_comb begin
        priority if (i_col_count == '0) begin
            cols_in_use = mvm_pkg::CCNT_W'(1);
        end else if (i_col_count > mvm_pkg::COL_LIMIT_C) begin
            cols_in_use = mvm_pkg::COL_LIMIT_C;
        end else begin
            cols_in_use = i_col_count;
        end
        last_col_idx = cols_in_use - mvm_pkg::CCNT_W'(1);
    end

    // Classify the incoming request.
    always_comb begin
        cls_item.cmd      = mvm_pkg::t_cmd'(i_command);
        cls_item.column   = i_column;
        cls_item.value    = i_value;
        cls_item.last_col = (i_column == last_col_idx[mvm_pkg::COL_W-1:0]);
        cls_item.in_range = (32'(i_column) < 32'(mvm_pkg::MAX_COLS));
    end

    // The holding register drains into the queue whenever the queue has room.
    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_item = r_item;
    assign n_valid  = accept || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= cls_item;
        end
    end

endmodule

`default_nettype wire

/* src/mvm_queue.sv */
// ----------------------------------------------------------------------------
// mvm_queue
// Short first-in first-out queue of classified requests between the front
// and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  mvm_pkg::t_item      i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output mvm_pkg::t_item      o_item
);

    mvm_pkg::t_item                 r_mem [mvm_pkg::QUEUE_DEPTH];
    logic [mvm_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [mvm_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [mvm_pkg::Q_CNT_W-1:0]    r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == mvm_pkg::Q_CNT_W'(mvm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == mvm_pkg::Q_PTR_W'(mvm_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + mvm_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == mvm_pkg::Q_PTR_W'(mvm_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + mvm_pkg::Q_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + mvm_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - mvm_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* src/mvm_back.sv */
// ----------------------------------------------------------------------------
// mvm_back
// Executes requests: vector store access, multiply, accumulate, row
// bookkeeping, and a small result buffer toward the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [mvm_pkg::ROW_W-1:0]    i_row_count,
    input  wire logic                         i_q_valid,
    input  mvm_pkg::t_item                    i_q_item,
    output logic                              o_q_pop,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output mvm_pkg::t_result                  o_result
);

    // Vector store.
    logic signed [mvm_pkg::VAL_W-1:0]  r_vec_mem [mvm_pkg::MAX_COLS];
    logic [mvm_pkg::ADDR_W-1:0]        vec_addr;

    // Pipeline stages.
    logic                              r_s1_v;
    mvm_pkg::t_item                    r_s1;
    logic signed [mvm_pkg::VAL_W-1:0]  r_x;
    logic                              r_s2_v;
    mvm_pkg::t_stage2                  r_s2;
    logic signed [mvm_pkg::VAL_W-1:0]  x_sel;

    // Accumulation and row state.
    logic signed [mvm_pkg::SUM_W-1:0]  r_acc;
    logic signed [mvm_pkg::SUM_W-1:0]  n_sum;
    logic [mvm_pkg::ROW_W-1:0]         r_row_cnt;
    logic [mvm_pkg::ROW_W-1:0]         last_idx;
    logic                              is_last_row;
    logic                              do_mac;
    logic                              row_done;
    mvm_pkg::t_result                  res;

    // Result buffer.
    mvm_pkg::t_result                  r_out_mem [mvm_pkg::OUT_DEPTH];
    logic [mvm_pkg::O_PTR_W-1:0]       r_out_wr;
    logic [mvm_pkg::O_PTR_W-1:0]       r_out_rd;
    logic [mvm_pkg::O_CNT_W-1:0]       r_out_count;
    logic [mvm_pkg::O_CNT_W:0]         committed;
    logic                              out_pop;

    // Issue only when the result buffer can absorb everything in flight.
    assign committed = (mvm_pkg::O_CNT_W + 1)'(r_out_count)
                     + (mvm_pkg::O_CNT_W + 1)'(r_s1_v)
                     + (mvm_pkg::O_CNT_W + 1)'(r_s2_v);
    assign o_q_pop   = i_q_valid &&
                       (committed < (mvm_pkg::O_CNT_W + 1)'(mvm_pkg::OUT_DEPTH));
    assign vec_addr  = mvm_pkg::ADDR_W'(i_q_item.column);

    // Stage 1: vector store write for loads, registered read for all.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_item.cmd == mvm_pkg::CMD_LOAD) && i_q_item.in_range) begin
            r_vec_mem[vec_addr] <= i_q_item.value;
        end
        r_x <= r_vec_mem[vec_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1 <= i_q_item;
        end
    end

    // Stage 2: exact Q16.16 product.
    assign x_sel = r_s1.in_range ? r_x : '0;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2.cmd      <= r_s1.cmd;
            r_s2.last_col <= r_s1.last_col;
            r_s2.prod     <= r_s1.value * x_sel;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= o_q_pop;
            r_s2_v <= r_s1_v;
        end
    end

    // Stage 3: accumulate and close the row on its last column.
    assign do_mac      = r_s2_v && (r_s2.cmd == mvm_pkg::CMD_MATRIX);
    assign row_done    = do_mac && r_s2.last_col;
    assign n_sum       = r_acc + {{(mvm_pkg::SUM_W - mvm_pkg::PROD_W){r_s2.prod[mvm_pkg::PROD_W-1]}},
                                  r_s2.prod};
    assign last_idx    = i_row_count - mvm_pkg::ROW_W'(1);
    assign is_last_row = (r_row_cnt == last_idx);

    always_comb begin
        res.row_index = r_row_cnt;
        res.row_sum   = n_sum;
        res.last_row  = is_last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_row_cnt <= '0;
        end else if (row_done) begin
            r_acc     <= '0;
            r_row_cnt <= is_last_row ? '0 : r_row_cnt + mvm_pkg::ROW_W'(1);
        end else if (do_mac) begin
            r_acc     <= n_sum;
        end
    end

    // Result buffer toward the output side.
    assign o_empty  = (r_out_count == '0);
    assign out_pop  = i_pop && !o_empty;
    assign o_result = r_out_mem[r_out_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (row_done) begin
                r_out_wr <= (r_out_wr == mvm_pkg::O_PTR_W'(mvm_pkg::OUT_DEPTH - 1))
                            ? '0 : r_out_wr + mvm_pkg::O_PTR_W'(1);
            end
            if (out_pop) begin
                r_out_rd <= (r_out_rd == mvm_pkg::O_PTR_W'(mvm_pkg::OUT_DEPTH - 1))
                            ? '0 : r_out_rd + mvm_pkg::O_PTR_W'(1);
            end
            unique case ({row_done, out_pop})
                2'b10:   r_out_count <= r_out_count + mvm_pkg::O_CNT_W'(1);
                2'b01:   r_out_count <= r_out_count - mvm_pkg::O_CNT_W'(1);
                default: r_out_count <= r_out_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_done) begin
            r_out_mem[r_out_wr] <= res;
        end
    end

endmodule

`default_nettype wire

/* src/matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply: dense y = A*x in Q8.8 with Q32.16 row sums.
// Path: front register, queue, store read, multiply, accumulate, result buffer.
// Throughput: one request per cycle absent back-pressure, set by one MAC.
// Reset: synchronous, empties the queues, clears the accumulator and row
// counter, and returns the registers to their default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_multiply (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port.
    input  wire logic                             i_cfg_we,
    input  wire logic [0:0]                       i_cfg_index,
    input  wire logic [mvm_pkg::CFG_W-1:0]        i_cfg_data,
    // Request side.
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [0:0]                       i_command,
    input  wire logic [mvm_pkg::COL_W-1:0]        i_column,
    input  wire logic signed [mvm_pkg::VAL_W-1:0] i_value,
    // Result side.
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [mvm_pkg::ROW_W-1:0]             o_row_index,
    output logic signed [mvm_pkg::SUM_W-1:0]      o_row_sum,
    output logic                                  o_last_row
);

    logic [mvm_pkg::CCNT_W-1:0] r_col_count;
    logic [mvm_pkg::ROW_W-1:0]  r_row_count;
    logic                       q_full;
    logic                       q_push;
    mvm_pkg::t_item             q_in_item;
    logic                       q_valid;
    logic                       q_pop;
    mvm_pkg::t_item             q_out_item;
    mvm_pkg::t_result           result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= mvm_pkg::CCNT_W'(1024);
            r_row_count <= mvm_pkg::ROW_W'(1024);
        end else if (i_cfg_we) begin
            unique case (mvm_pkg::t_cfg_index'(i_cfg_index))
                mvm_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data[mvm_pkg::CCNT_W-1:0];
                mvm_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[mvm_pkg::ROW_W-1:0];
                default:                r_row_count <= r_row_count;
            endcase
        end
    end

    // Front end: accept and classify.
    mvm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col_count (r_col_count),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_column    (i_column),
        .i_value     (i_value),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    // Decoupling queue.
    mvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // Back end: execute and buffer results.
    mvm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_count (r_row_count),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_row_index = result.row_index;
    assign o_row_sum   = result.row_sum;
    assign o_last_row  = result.last_row;

endmodule

`default_nettype wire

/* src/mvm_checker.sv */
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks of the matrix-vector multiply, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_vector_multiply_assert.svh"

module mvm_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    input  wire logic                             full,
    input  wire logic                             empty,
    input  wire logic                             pop,
    input  wire logic [mvm_pkg::ROW_W-1:0]        o_row_index,
    input  wire logic signed [mvm_pkg::SUM_W-1:0] o_row_sum,
    input  wire logic                             o_last_row
);

    // Reset flushes the result buffer.
    `MVM_ASSERT_AFTER_RESET(a_empty_after_reset, empty, "result pending after reset")

    // Reset flushes the front holding register and queue.
    `MVM_ASSERT_AFTER_RESET(a_not_full_after_reset, !full, "input blocked after reset")

    // A waiting result holds until it is taken.
    `MVM_ASSERT_NXT(a_result_holds, !empty && !pop,
        !empty && $stable(o_row_index) && $stable(o_row_sum) && $stable(o_last_row),
        "waiting result changed before pop")

    // The input can only block after a request was offered in the cycle before.
    `MVM_ASSERT_IMP(a_full_needs_push, $rose(full), $past(push), "full rose without a push")

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (.*);

`default_nettype wire

/* tb/tb_matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply
// Self-checking bench for the matrix-vector multiply block. Requests drive the
// vector store and stream matrix rows. A bit-accurate predictor keeps its own
// vector copy, row sum, row counter and registers, and every popped row is
// checked in order. Directed tests cover register extremes, a full-width row,
// a zero row count, a long row with a wide sum, and a stalled receiver;
// random traffic follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_vector_multiply;

    import mvm_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 2_000_000;
    // Vector entries loaded up front; matrix reads stay inside these and the top entry.
    localparam int LOADED_COLS   = 128;

    // Clock, reset and block ports.
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    t_cfg_index              i_cfg_index = CFG_COL_COUNT;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    push        = 1'b0;
    logic                    full;
    t_cmd                    i_command   = CMD_LOAD;
    logic [COL_W-1:0]        i_column    = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    empty;
    logic                    pop         = 1'b0;
    logic [ROW_W-1:0]        o_row_index;
    logic signed [SUM_W-1:0] o_row_sum;
    logic                    o_last_row;

    // Bench control.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic recv_hold     = 1'b0;
    int   error_count   = 0;

    // Predictor state: vector copy, running sum, row counter and registers.
    logic [VAL_W-1:0]  x_shadow [MAX_COLS];
    logic [SUM_W-1:0]  sum_shadow = '0;
    logic [ROW_W-1:0]  row_shadow = '0;
    logic [CCNT_W-1:0] cols_reg   = CCNT_W'(1024);
    logic [ROW_W-1:0]  rows_reg   = ROW_W'(1024);

    // Finished rows that the block still owes, oldest first.
    t_result pending_rows [$];

    matrix_vector_multiply dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_command   (i_command),
        .i_column    (i_column),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .o_row_index (o_row_index),
        .o_row_sum   (o_row_sum),
        .o_last_row  (o_last_row)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic flag_error(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Apply one accepted request to the predictor and queue any finished row.
    function automatic void predict_row(input t_cmd cmd, input logic [COL_W-1:0] col,
                                        input logic [VAL_W-1:0] val);
        logic signed [PROD_W-1:0] prod;
        logic [VAL_W-1:0]         xv;
        logic [ROW_W-1:0]         last_idx;
        int unsigned              width;
        t_result                  row;

        if (cmd == CMD_LOAD) begin
            if (col < MAX_COLS) begin
                x_shadow[col] = val;
            end
            return;
        end
        xv = (col < MAX_COLS) ? x_shadow[col] : '0;
        prod = $signed(val) * $signed(xv);
        sum_shadow = sum_shadow + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};

        // A column count of zero acts as one; large counts clip to the limit.
        width = (cols_reg == 0) ? 1 : ((cols_reg > COL_LIMIT) ? COL_LIMIT : cols_reg);
        if (col != width - 1) begin
            return;
        end
        last_idx = rows_reg - 1'b1;
        row.row_index = row_shadow;
        row.row_sum   = sum_shadow;
        row.last_row  = (row_shadow == last_idx);
        pending_rows.push_back(row);
        sum_shadow = '0;
        row_shadow = row.last_row ? '0 : row_shadow + 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Offer one request after a random idle gap and hold it until accepted.
    task automatic send_request(input t_cmd cmd, input logic [COL_W-1:0] col,
                                input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_command <= cmd;
        i_column  <= col;
        i_value   <= val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_row(cmd, col, val);
    endtask

    // Stop offering requests and wait until every owed row has come out.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_COL_COUNT: cols_reg = data[CCNT_W-1:0];
            CFG_ROW_COUNT: rows_reg = data[ROW_W-1:0];
            default: ;
        endcase
    endtask

    // Compare a popped row against the oldest owed row.
    task automatic check_row();
        t_result want;

        if (pending_rows.size() == 0) begin
            flag_error($sformatf("row %0d popped with none owed", o_row_index));
            return;
        end
        want = pending_rows.pop_front();
        if (o_row_index !== want.row_index) begin
            flag_error($sformatf("row_index got %0d want %0d", o_row_index, want.row_index));
        end
        if (o_row_sum !== want.row_sum) begin
            flag_error($sformatf("row %0d row_sum got %0d want %0d", want.row_index,
                                 o_row_sum, $signed(want.row_sum)));
        end
        if (o_last_row !== want.last_row) begin
            flag_error($sformatf("row %0d last_row got %0b want %0b", want.row_index,
                                 o_last_row, want.last_row));
        end
    endtask

    // Receiver: check each accepted row, then decide whether to pop next cycle.
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            check_row();
        end
        pop <= i_rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Reset register values, the low vector entries and the top entry loaded,
    // and one full-width row that closes on the top column.
    task automatic test_full_width_row();
        for (int c = 0; c < LOADED_COLS; c++) begin
            send_request(CMD_LOAD, COL_W'(c), pick_value());
        end
        send_request(CMD_LOAD, COL_W'(MAX_COLS - 1), pick_value());
        for (int c = 0; c < LOADED_COLS; c++) begin
            send_request(CMD_MATRIX, COL_W'(c), pick_value());
        end
        send_request(CMD_MATRIX, COL_W'(MAX_COLS - 1), pick_value());
        wait_idle();
    endtask

    // Field extremes, dropped register bits, zero and oversized column counts.
    task automatic test_register_extremes();
        // Upper bits above the column count field are dropped, leaving two.
        write_reg(CFG_COL_COUNT, 16'hF802);
        write_reg(CFG_ROW_COUNT, 16'd2);
        send_request(CMD_LOAD, 10'd0, 16'h8000);
        send_request(CMD_LOAD, 10'd1, 16'h7FFF);
        send_request(CMD_MATRIX, 10'd0, 16'h8000);
        send_request(CMD_MATRIX, 10'd1, 16'h8000);
        send_request(CMD_MATRIX, 10'd0, 16'h7FFF);
        send_request(CMD_MATRIX, 10'd1, 16'h7FFF);
        // A column past the row end only accumulates.
        send_request(CMD_MATRIX, 10'd1023, 16'h7FFF);
        send_request(CMD_MATRIX, 10'd0, 16'hFFFF);
        send_request(CMD_MATRIX, 10'd1, 16'h0001);
        wait_idle();

        // A column count of zero behaves as one column.
        write_reg(CFG_COL_COUNT, 16'd0);
        send_request(CMD_MATRIX, 10'd0, 16'h8000);
        send_request(CMD_MATRIX, 10'd0, 16'h0000);
        wait_idle();

        // An oversized column count clips to the store size.
        write_reg(CFG_COL_COUNT, 16'h07FF);
        write_reg(CFG_ROW_COUNT, 16'hFFFF);
        send_request(CMD_MATRIX, 10'd5, 16'h7FFF);
        send_request(CMD_MATRIX, 10'd1023, 16'h8000);
        wait_idle();
    endtask

    // A row count of zero marks only the top counter value as the last row;
    // then a row count below the counter is not reached on the next rows.
    task automatic test_row_count_zero();
        write_reg(CFG_COL_COUNT, 16'd1);
        write_reg(CFG_ROW_COUNT, 16'd0);
        for (int k = 0; k < 20; k++) begin
            send_request(CMD_MATRIX, 10'd0, pick_value());
        end
        wait_idle();
        write_reg(CFG_ROW_COUNT, 16'd3);
        for (int k = 0; k < 4; k++) begin
            send_request(CMD_MATRIX, 10'd0, pick_value());
        end
        wait_idle();
    endtask

    // A long row of extreme products grows the sum well past 32 bits.
    task automatic test_long_row();
        write_reg(CFG_COL_COUNT, 16'd1024);
        send_request(CMD_LOAD, 10'd0, 16'h8000);
        for (int k = 0; k < 96; k++) begin
            send_request(CMD_MATRIX, 10'd0, 16'h8000);
        end
        send_request(CMD_MATRIX, 10'd1023, 16'h0000);
        wait_idle();
    endtask

    // The receiver stops for a long stretch so the block fills and stalls input.
    task automatic test_backpressure();
        write_reg(CFG_COL_COUNT, 16'd1);
        write_reg(CFG_ROW_COUNT, 16'd5);
        fork
            begin
                recv_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                recv_hold <= 1'b0;
            end
            begin
                for (int k = 0; k < 60; k++) begin
                    send_request(CMD_MATRIX, 10'd0, pick_value());
                end
            end
        join
        wait_idle();
    endtask

    // Mostly well-formed rows with random content, plus stray loads, stray
    // matrix requests and rows cut short.
    task automatic run_random_phase(input int n_requests, input int max_cols,
                                    input int send_pct, input int recv_pct);
        int sent;
        int width;
        int roll;

        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        width = $urandom_range(1, max_cols);
        write_reg(CFG_COL_COUNT, CFG_W'(width) | CFG_W'($urandom_range(31) << CCNT_W));
        write_reg(CFG_ROW_COUNT,
                  ($urandom_range(3) == 0) ? 16'hFFFF : CFG_W'($urandom_range(1, 6)));
        sent = 0;
        while (sent < n_requests) begin
            for (int c = 0; c < width; c++) begin
                roll = $urandom_range(99);
                if (roll < 6) begin
                    send_request(CMD_LOAD, COL_W'($urandom), pick_value());
                    sent++;
                end else if (roll < 10) begin
                    send_request(CMD_MATRIX, COL_W'($urandom_range(LOADED_COLS - 1)),
                                 pick_value());
                    sent++;
                end
                if (roll >= 97) break;
                send_request(CMD_MATRIX, COL_W'(c), pick_value());
                sent++;
            end
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(110, 12, 10, 75);
        run_random_phase(110, 40, 10, 75);
        run_random_phase(110, 12, 75, 10);
        run_random_phase(110, 40, 75, 10);
        run_random_phase(110, 12, 0, 0);
        run_random_phase(110, 40, 0, 0);
    endtask

    // Test sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct = 75;
        test_full_width_row();
        test_register_extremes();
        test_row_count_zero();
        test_long_row();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (error_count == 0 && pending_rows.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
